// ----- hdl/dep_pkg.sv -----
// ----------------------------------------------------------------------------
// dep_pkg: shared types and constants of the dual echo pulse ranger
// Request mode codes, channel state limits and the divide-by-1000 constants.
// ----------------------------------------------------------------------------
package dep_pkg;

	// Request mode codes
	typedef enum logic [1:0] {
		MODE_EVENT = 2'd0,
		MODE_RD0   = 2'd1,
		MODE_RD1   = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// Channels that have capture inputs on the ports
	localparam int unsigned IN_CH        = 2;
	localparam int unsigned CHANNELS_DEF = 2;

	// Read mode that selects each port channel
	localparam mode_t RD_MODE [IN_CH] = '{MODE_RD0, MODE_RD1};

	localparam int unsigned CNT_W   = 16;
	localparam int unsigned OVF_W   = 6;
	localparam int unsigned TICKS_W = OVF_W + CNT_W;   // overflow count : end count
	localparam int unsigned X_W     = TICKS_W + 5;     // ticks * 17

	localparam logic [CNT_W-1:0] NO_ECHO_RST = 16'd10000;
	localparam logic [OVF_W-1:0] OVF_MAX     = 6'h3F;
	localparam logic [CNT_W-1:0] END_TIMEOUT = 16'hFFFF;
	localparam logic [CNT_W-1:0] LEN_MAX     = 16'hFFFF;

	// floor(x / 1000) = floor((x >> 3) * DIV_MAGIC >> DIV_SHIFT), exact for x < 2^27
	localparam int unsigned      DQ_W      = X_W - 3;  // x / 8
	localparam int unsigned      MAGIC_W   = 25;
	localparam int unsigned      PROD_W    = DQ_W + MAGIC_W;
	localparam int unsigned      DIV_SHIFT = 31;
	localparam logic [MAGIC_W-1:0] DIV_MAGIC = 25'd17179870;
	localparam int unsigned      Q_W       = PROD_W - DIV_SHIFT;

endpackage

// ----- hdl/dual_echo_pulse_ranger.sv -----
// ----------------------------------------------------------------------------
// dual_echo_pulse_ranger: two-channel ultrasonic echo pulse-width meter
// Tracks rising/falling captures and timer overflows per channel; a read
// request returns the pulse length in centimeters and clears the channel.
// ----------------------------------------------------------------------------
// Stages: channel state updates at acceptance, and the result then passes
//   stage 1 and stage 2. Throughput: one request per cycle unless stalled;
//   the centimeter scaling (one constant multiply) runs in the second stage.
// Reset: arst_n clears channel state and both stage valids, and loads
//   no_echo_length with 10000.
module dual_echo_pulse_ranger #(
	parameter int unsigned CHANNELS = dep_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic        overflow,
	input  logic        capture_ch0,
	input  logic        capture_ch1,
	input  logic [15:0] captured_count_ch0,
	input  logic [15:0] captured_count_ch1,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_read,
	output logic [15:0] length_cm,
	output logic        echo_seen,
	output logic        falling_armed_ch0,
	output logic        falling_armed_ch1
);

	localparam int unsigned CW = dep_pkg::CNT_W;
	localparam int unsigned OW = dep_pkg::OVF_W;
	localparam int unsigned TW = dep_pkg::TICKS_W;
	localparam int unsigned XW = dep_pkg::X_W;
	localparam int unsigned NI = dep_pkg::IN_CH;

	// handshake
	logic in_fire;
	logic s1_en;
	logic s2_en;
	logic ev;
	logic rd_any;

	// configuration register
	logic [CW-1:0] no_echo_q;

	// channel state
	logic          done_q [CHANNELS];
	logic          high_q [CHANNELS];
	logic [OW-1:0] ocnt_q [CHANNELS];
	logic [CW-1:0] endc_q [CHANNELS];
	logic          fall_q [CHANNELS];

	// per-channel read snapshot and next polarity
	logic [CHANNELS-1:0] rd_done;
	logic [TW-1:0]       rd_ticks [CHANNELS];
	logic [CHANNELS-1:0] fall_nxt;
	logic [NI-1:0]       fall_port;

	logic [NI-1:0]       cap_v;
	logic [CW-1:0]       val_v [NI];

	// read result ahead of scaling
	logic          seen_c;
	logic [TW-1:0] ticks_c;
	logic [XW-1:0] x_c;

	// stage 1
	logic          vld_s1;
	logic          is_read_s1;
	logic          seen_s1;
	logic [XW-1:0] x_s1;
	logic [NI-1:0] fall_s1;

	// scaling
	logic [dep_pkg::PROD_W-1:0] prod;
	logic [dep_pkg::Q_W-1:0]    quo;
	logic [CW-1:0]              len_c;

	// stage 2 (result register)
	logic          vld_s2;
	logic          is_read_s2;
	logic          seen_s2;
	logic [CW-1:0] len_s2;
	logic [NI-1:0] fall_s2;

	assign cap_v    = {capture_ch1, capture_ch0};
	assign val_v[0] = captured_count_ch0;
	assign val_v[1] = captured_count_ch1;

	// Pipeline flow control: each stage moves when the one after it frees up
	assign s2_en    = !vld_s2 || out_ready;
	assign s1_en    = !vld_s1 || s2_en;
	assign in_ready = s1_en;
	assign in_fire  = in_valid && in_ready;
	assign ev       = in_fire && (mode == dep_pkg::MODE_EVENT);
	assign rd_any   = (mode == dep_pkg::MODE_RD0) || (mode == dep_pkg::MODE_RD1);

	// Configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_echo_q <= dep_pkg::NO_ECHO_RST;
		end else if (cfg_valid && cfg_ready) begin
			no_echo_q <= cfg_data;
		end
	end

	// Per-channel pulse tracking
	for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
		logic          cap;
		logic [CW-1:0] val;
		logic          rd;
		logic          done_n;
		logic          high_n;
		logic [OW-1:0] ocnt_n;
		logic [CW-1:0] endc_n;
		logic          fall_n;

		if (c < NI) begin : g_port
			assign cap = cap_v[c];
			assign val = val_v[c];
			assign rd  = in_fire && (mode == dep_pkg::RD_MODE[c]);
		end else begin : g_noport
			// channel without inputs: never sees events or reads
			assign cap = 1'b0;
			assign val = '0;
			assign rd  = 1'b0;
		end

		// event update, overflow before capture, then read clear
		always_comb begin
			done_n = done_q[c];
			high_n = high_q[c];
			ocnt_n = ocnt_q[c];
			endc_n = endc_q[c];
			fall_n = fall_q[c];
			if (ev && !done_q[c]) begin
				if (overflow && high_q[c]) begin
					if (ocnt_q[c] == dep_pkg::OVF_MAX) begin
						done_n = 1'b1;
						endc_n = dep_pkg::END_TIMEOUT;
					end else begin
						ocnt_n = ocnt_q[c] + OW'(1);
					end
				end
				if (cap) begin
					if (high_q[c]) begin
						// falling edge ends the pulse; overrides a timeout value
						done_n = 1'b1;
						endc_n = val;
						fall_n = 1'b0;
					end else begin
						// rising edge starts a pulse
						done_n = 1'b0;
						high_n = 1'b1;
						ocnt_n = '0;
						endc_n = '0;
						fall_n = 1'b1;
					end
				end
			end
			if (rd) begin
				done_n = 1'b0;
				high_n = 1'b0;
				ocnt_n = '0;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q[c] <= 1'b0;
				high_q[c] <= 1'b0;
				ocnt_q[c] <= '0;
				endc_q[c] <= '0;
				fall_q[c] <= 1'b0;
			end else begin
				done_q[c] <= done_n;
				high_q[c] <= high_n;
				ocnt_q[c] <= ocnt_n;
				endc_q[c] <= endc_n;
				fall_q[c] <= fall_n;
			end
		end

		assign rd_done[c]  = rd && done_q[c];
		assign rd_ticks[c] = rd_done[c] ? {ocnt_q[c], endc_q[c]} : '0;
		assign fall_nxt[c] = fall_n;
	end

	// Polarity outputs; a channel beyond CHANNELS reads as rising
	for (genvar p = 0; p < NI; p++) begin : g_pol
		if (p < CHANNELS) begin : g_have
			assign fall_port[p] = fall_nxt[p];
		end else begin : g_miss
			assign fall_port[p] = 1'b0;
		end
	end

	// Collect the read channel's snapshot and form ticks * 17
	always_comb begin
		ticks_c = '0;
		for (int unsigned k = 0; k < CHANNELS; k++) begin
			ticks_c = ticks_c | rd_ticks[k];
		end
		seen_c = |rd_done;
		x_c    = {1'b0, ticks_c, 4'b0000} + {5'b00000, ticks_c};
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_en) begin
			vld_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			is_read_s1 <= rd_any;
			seen_s1    <= seen_c;
			x_s1       <= x_c;
			fall_s1    <= fall_port;
		end
	end

	// Divide by 1000 via reciprocal multiply, then saturate and select
	always_comb begin
		prod = {{dep_pkg::MAGIC_W{1'b0}}, x_s1[XW-1:3]}
		     * {{dep_pkg::DQ_W{1'b0}}, dep_pkg::DIV_MAGIC};
		quo  = prod[dep_pkg::PROD_W-1:dep_pkg::DIV_SHIFT];
		if (!is_read_s1) begin
			len_c = '0;
		end else if (!seen_s1) begin
			len_c = no_echo_q;
		end else if (quo > {{(dep_pkg::Q_W-CW){1'b0}}, dep_pkg::LEN_MAX}) begin
			len_c = dep_pkg::LEN_MAX;
		end else begin
			len_c = quo[CW-1:0];
		end
	end

	// Stage 2 register, drives the result port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && vld_s1) begin
			is_read_s2 <= is_read_s1;
			seen_s2    <= seen_s1;
			len_s2     <= len_c;
			fall_s2    <= fall_s1;
		end
	end

	assign out_valid         = vld_s2;
	assign is_read           = is_read_s2;
	assign length_cm         = len_s2;
	assign echo_seen         = seen_s2;
	assign falling_armed_ch0 = fall_s2[0];
	assign falling_armed_ch1 = fall_s2[1];

endmodule

// ----- hdl/dep_chk.sv -----
// ----------------------------------------------------------------------------
// dep_chk: port-level checker for the dual echo pulse ranger
// Watches the request and result ports and flags ordering or content slips.
// ----------------------------------------------------------------------------
module dep_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  mode,
	input logic        out_valid,
	input logic        out_ready,
	input logic        is_read,
	input logic [15:0] length_cm,
	input logic        echo_seen
);

	logic in_fire;
	logic rd_req;

	assign in_fire = in_valid && in_ready;
	assign rd_req  = (mode == dep_pkg::MODE_RD0) || (mode == dep_pkg::MODE_RD1);

	// stalled result holds its content
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_read) && $stable(length_cm)
			&& $stable(echo_seen))
		else $error("result changed while stalled");

	// non-read results carry no length and no echo
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_read |-> (length_cm == 16'd0) && !echo_seen)
		else $error("non-read result with length or echo");

	// a read request passes both stages to the result port unless held up
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && rd_req) ##1 (!out_valid || out_ready) |=> out_valid && is_read)
		else $error("read result missing after two cycles");

endmodule

bind dual_echo_pulse_ranger dep_chk u_dep_chk (.*);

// ----- tb/echo_ranger_checker.sv -----
// ----------------------------------------------------------------------------
// echo_ranger_checker: scoreboard for the dual echo pulse ranger
// Watches the config, request and result handshakes, keeps its own copy of
// the per-channel pulse state, predicts each result and compares it with
// the oldest prediction. Exposes the mismatch count and the number of
// results still owed.
// ----------------------------------------------------------------------------
module echo_ranger_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic        overflow,
	input  logic        capture_ch0,
	input  logic        capture_ch1,
	input  logic [15:0] captured_count_ch0,
	input  logic [15:0] captured_count_ch1,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        is_read,
	input  logic [15:0] length_cm,
	input  logic        echo_seen,
	input  logic        falling_armed_ch0,
	input  logic        falling_armed_ch1,
	output int          errors,
	output int          waiting
);

	localparam int unsigned CW = dep_pkg::CNT_W;
	localparam int unsigned OW = dep_pkg::OVF_W;
	localparam int unsigned NI = dep_pkg::IN_CH;

	typedef struct packed {
		logic          is_read;
		logic [CW-1:0] length_cm;
		logic          echo_seen;
		logic          armed_ch0;
		logic          armed_ch1;
	} echo_report_t;

	// shadow of the per-channel pulse state
	logic          done_q  [NI];
	logic          high_q  [NI];
	logic [OW-1:0] ovf_cnt [NI];
	logic [CW-1:0] end_cnt [NI];
	logic          armed_q [NI];
	logic [CW-1:0] no_echo_cm;

	echo_report_t echo_reports_q [$];

	initial begin
		errors  = 0;
		waiting = 0;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("echo_ranger_checker: %0t: %s", $time, msg);
	endtask

	// one channel's reaction to a timer event
	task automatic step_channel(input int c, input logic ovf, input logic cap,
			input logic [CW-1:0] val);
		if (done_q[c])
			return;
		if (ovf && high_q[c]) begin
			if (ovf_cnt[c] == dep_pkg::OVF_MAX) begin
				done_q[c]  = 1'b1;
				end_cnt[c] = dep_pkg::END_TIMEOUT;
			end else begin
				ovf_cnt[c] = ovf_cnt[c] + OW'(1);
			end
		end
		if (cap) begin
			if (high_q[c]) begin
				done_q[c]  = 1'b1;
				end_cnt[c] = val;
				armed_q[c] = 1'b0;
			end else begin
				ovf_cnt[c] = '0;
				end_cnt[c] = '0;
				done_q[c]  = 1'b0;
				high_q[c]  = 1'b1;
				armed_q[c] = 1'b1;
			end
		end
	endtask

	// update the shadow state for one request and queue the result it owes
	task automatic predict_echo_report();
		echo_report_t      r;
		int                c;
		longint unsigned   ticks;
		longint unsigned   cm;
		r = '0;
		case (dep_pkg::mode_t'(mode))
			dep_pkg::MODE_EVENT: begin
				step_channel(0, overflow, capture_ch0, captured_count_ch0);
				step_channel(1, overflow, capture_ch1, captured_count_ch1);
			end
			dep_pkg::MODE_RD0, dep_pkg::MODE_RD1: begin
				c = (dep_pkg::mode_t'(mode) == dep_pkg::MODE_RD0) ? 0 : 1;
				r.is_read   = 1'b1;
				r.length_cm = no_echo_cm;
				if (done_q[c]) begin
					ticks = 64'({ovf_cnt[c], end_cnt[c]});
					cm    = (ticks * 17) / 1000;
					r.length_cm = (cm > dep_pkg::LEN_MAX) ? dep_pkg::LEN_MAX
						: cm[CW-1:0];
					r.echo_seen = 1'b1;
				end
				done_q[c]  = 1'b0;
				high_q[c]  = 1'b0;
				ovf_cnt[c] = '0;
			end
			default: ;	// MODE_NONE: no state change
		endcase
		r.armed_ch0 = armed_q[0];
		r.armed_ch1 = armed_q[1];
		echo_reports_q.push_back(r);
	endtask

	// compare a delivered result with the oldest prediction
	task automatic check_echo_report();
		echo_report_t w;
		if (echo_reports_q.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected (len %0d)", length_cm));
			return;
		end
		w = echo_reports_q.pop_front();
		if (is_read !== w.is_read)
			report_mismatch($sformatf("is_read got %b want %b", is_read, w.is_read));
		if (length_cm !== w.length_cm)
			report_mismatch($sformatf("length_cm got %0d want %0d", length_cm, w.length_cm));
		if (echo_seen !== w.echo_seen)
			report_mismatch($sformatf("echo_seen got %b want %b", echo_seen, w.echo_seen));
		if (falling_armed_ch0 !== w.armed_ch0)
			report_mismatch($sformatf("falling_armed_ch0 got %b want %b",
				falling_armed_ch0, w.armed_ch0));
		if (falling_armed_ch1 !== w.armed_ch1)
			report_mismatch($sformatf("falling_armed_ch1 got %b want %b",
				falling_armed_ch1, w.armed_ch1));
	endtask

	// watch the three handshakes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NI; c++) begin
				done_q[c]  = 1'b0;
				high_q[c]  = 1'b0;
				ovf_cnt[c] = '0;
				end_cnt[c] = '0;
				armed_q[c] = 1'b0;
			end
			no_echo_cm = dep_pkg::NO_ECHO_RST;
			echo_reports_q.delete();
			waiting = 0;
		end else begin
			if (out_valid && out_ready)
				check_echo_report();
			if (cfg_valid && cfg_ready)
				no_echo_cm = cfg_data;
			if (in_valid && in_ready)
				predict_echo_report();
			waiting = echo_reports_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the dual echo pulse ranger
// Drives timer events and channel reads through four handshake phases,
// sweeps the no-echo length register, and leaves prediction and checking
// to echo_ranger_checker.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int QUIET_LIMIT  = 2000;	// cycles without any handshake
	localparam int HOLD_CYCLES  = 300;	// long receiver hold-off
	localparam int DRAIN_CYCLES = 8;	// pipeline is two stages deep
	localparam int PHASE_ITEMS  = 70;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = dep_pkg::MODE_EVENT;
	logic        overflow = 1'b0;
	logic        capture_ch0 = 1'b0;
	logic        capture_ch1 = 1'b0;
	logic [15:0] captured_count_ch0 = '0;
	logic [15:0] captured_count_ch1 = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        is_read;
	logic [15:0] length_cm;
	logic        echo_seen;
	logic        falling_armed_ch0;
	logic        falling_armed_ch1;

	int errors;
	int waiting;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	int requests_sent  = 0;
	int pulse_bursts   = 0;
	int long_bursts    = 0;

	always #2 clk = ~clk;

	dual_echo_pulse_ranger u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.overflow          (overflow),
		.capture_ch0       (capture_ch0),
		.capture_ch1       (capture_ch1),
		.captured_count_ch0(captured_count_ch0),
		.captured_count_ch1(captured_count_ch1),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.is_read           (is_read),
		.length_cm         (length_cm),
		.echo_seen         (echo_seen),
		.falling_armed_ch0 (falling_armed_ch0),
		.falling_armed_ch1 (falling_armed_ch1)
	);

	echo_ranger_checker u_chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.overflow          (overflow),
		.capture_ch0       (capture_ch0),
		.capture_ch1       (capture_ch1),
		.captured_count_ch0(captured_count_ch0),
		.captured_count_ch1(captured_count_ch1),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.is_read           (is_read),
		.length_cm         (length_cm),
		.echo_seen         (echo_seen),
		.falling_armed_ch0 (falling_armed_ch0),
		.falling_armed_ch1 (falling_armed_ch1),
		.errors            (errors),
		.waiting           (waiting)
	);

	// result side: random stalls, plus a counted hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready = 1'b0;
		end else if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: give up when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top: watchdog expired, %0d results outstanding", waiting);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	// one request, entered and left at a falling edge
	task automatic send_request(input dep_pkg::mode_t m, input logic ovf, input logic c0,
			input logic c1, input logic [15:0] v0, input logic [15:0] v1);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid           = 1'b1;
		mode               = m;
		overflow           = ovf;
		capture_ch0        = c0;
		capture_ch1        = c1;
		captured_count_ch0 = v0;
		captured_count_ch1 = v1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (m != dep_pkg::MODE_NONE)
			requests_sent++;
	endtask

	task automatic send_event(input logic ovf, input logic c0, input logic c1);
		send_request(dep_pkg::MODE_EVENT, ovf, c0, c1, 16'($urandom), 16'($urandom));
	endtask

	// write no_echo_length once the block has drained
	task automatic write_no_echo(input logic [15:0] v);
		in_valid = 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// rising capture, a run of overflows, optional falling capture, then read
	task automatic pulse_burst(input int ch, input int n_ovf, input logic close_ovf,
			input bit close);
		logic [1:0] cap;
		pulse_bursts++;
		if (n_ovf >= 55)
			long_bursts++;
		cap     = 2'($urandom_range(3)) & {1'b1, 1'b1};
		cap[ch] = 1'b1;
		if ($urandom_range(3) != 0)
			cap[1-ch] = 1'b0;
		send_event(1'($urandom_range(1)), cap[0], cap[1]);
		for (int i = 0; i < n_ovf; i++) begin
			cap = '0;
			if ($urandom_range(9) == 0)
				cap[1-ch] = 1'b1;
			send_event(1'b1, cap[0], cap[1]);
		end
		if (close) begin
			cap     = '0;
			cap[ch] = 1'b1;
			send_event(close_ovf, cap[0], cap[1]);
		end
		send_request(dep_pkg::RD_MODE[ch], 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 16'($urandom), 16'($urandom));
		if ($urandom_range(3) == 0)
			send_request(dep_pkg::RD_MODE[1-ch], 1'b0, 1'b0, 1'b0,
				16'($urandom), 16'($urandom));
	endtask

	// mostly well-formed pulses, the rest raw noise on every field
	task automatic random_traffic(input int quota);
		int target;
		int n;
		target = requests_sent + quota;
		while (requests_sent < target) begin
			if ($urandom_range(99) < 60) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(55, 70) : $urandom_range(4);
				pulse_burst($urandom_range(1), n, 1'($urandom_range(1)),
					$urandom_range(9) != 0);
			end else begin
				send_request(dep_pkg::mode_t'($urandom_range(3)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)),
					16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reads at reset, ignored mode, edge values, finished channel
		send_request(dep_pkg::MODE_RD0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_request(dep_pkg::MODE_RD1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_request(dep_pkg::MODE_NONE, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
		send_event(1'b1, 1'b0, 1'b0);
		send_request(dep_pkg::MODE_EVENT, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'h0000);
		send_event(1'b1, 1'b0, 1'b0);
		send_request(dep_pkg::MODE_EVENT, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'h0000);
		send_request(dep_pkg::MODE_EVENT, 1'b1, 1'b1, 1'b1, 16'h1234, 16'h4321);
		send_request(dep_pkg::MODE_RD0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_request(dep_pkg::MODE_RD1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
		send_request(dep_pkg::MODE_RD0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_request(dep_pkg::MODE_EVENT, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000);
		send_request(dep_pkg::MODE_EVENT, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000);
		send_request(dep_pkg::MODE_RD0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000);
		// overflow limit hit together with a capture, then a plain timeout
		pulse_burst(0, 63, 1'b1, 1'b1);
		pulse_burst(1, 64, 1'b0, 1'b0);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					write_no_echo(16'hFFFF);
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					write_no_echo(16'h0000);
					send_idle_pct  = 51;
					recv_stall_pct = 0;
				end
				2: begin
					write_no_echo(16'($urandom));
					send_idle_pct  = 0;
					recv_stall_pct = 51;
				end
				default: begin
					write_no_echo(16'd10000);
					send_idle_pct  = 7;
					recv_stall_pct = 7;
				end
			endcase
			// long result stall while requests keep coming
			if (p == 0)
				hold_left = HOLD_CYCLES;
			random_traffic(PHASE_ITEMS);
		end

		in_valid = 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("tb_top: %0d requests over four handshake mixes and a long result stall",
			requests_sent);
		$display("tb_top: %0d pulse sequences, %0d near the overflow limit, 4 no-echo settings",
			pulse_bursts, long_bursts);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
